>>> rtl/pds_pkg.sv
// Shared types and constants for the PLL divider search block.
package pds_pkg;

  localparam int unsigned HZ_W      = 32;
  localparam int unsigned PRE_W     = 4;
  localparam int unsigned MUL_W     = 8;
  localparam int unsigned SHIFT_W   = 6;
  localparam int unsigned DIV_W     = PRE_W + 1;
  localparam int unsigned MUL_OFS_W = 9;
  localparam int unsigned ICO_W     = HZ_W + MUL_OFS_W;
  localparam int unsigned CNT_W     = 8;

  localparam logic [PRE_W-1:0] PREDIV_MAX  = 4'd15;
  localparam logic [MUL_W-1:0] MULT_MAX    = 8'd255;
  localparam logic [CNT_W-1:0] MULT_OFFSET = 8'd16;
  localparam logic [CNT_W-1:0] DIV_STEPS   = 8'd32;
  localparam logic [HZ_W-1:0]  REF_FLOOR_HZ = 32'd4000000;
  localparam logic [ICO_W-1:0] ICO_FLOOR_HZ = 41'd48000000;

  typedef struct packed {
    logic [HZ_W-1:0] reference_hz;
    logic [HZ_W-1:0] requested_hz;
  } pds_in_t;

  typedef struct packed {
    logic [PRE_W-1:0]   prediv_field;
    logic [MUL_W-1:0]   mult_field;
    logic [SHIFT_W-1:0] shift_field;
    logic [HZ_W-1:0]    achieved_hz;
    logic               found;
  } pds_out_t;

  typedef struct packed {
    logic             load;
    logic             div_init;
    logic             div_step;
    logic             acc_init;
    logic             acc_step;
    logic             scan;
    logic             publish;
    logic [PRE_W-1:0] pre;
    logic [MUL_W-1:0] mul;
  } pds_cmd_t;

  typedef struct packed {
    logic pre_ok;
  } pds_sts_t;

endpackage

>>> rtl/pll_divider_search_top.sv
// Top level of the PLL divider search block.
//
//  channel   direction  handshake                     payload
//  request   in         request_valid / request_ready reference_hz, requested_hz
//  result    out        result_valid / result_ready   prediv, mult, shift, achieved_hz, found
//
// One request at a time. Each pre-divider runs an init step, 32 restoring
// division steps and a check; one that passes the 4 MHz floor adds a warm-up to
// multiplier 16 and a scan of 256 multipliers, one multiplier per cycle from
// the oscillator accumulator.
// A held result stalls only the publish step; a new request is taken meanwhile.
// Reset is synchronous and clears control state and the best-setting registers.
module pll_divider_search_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_ready,
  input  pds_pkg::pds_in_t  request,
  output logic              result_valid,
  input  logic              result_ready,
  output pds_pkg::pds_out_t result
);
  import pds_pkg::*;

  pds_cmd_t cmd;
  pds_sts_t sts;

  pds_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_ready (request_ready),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .sts           (sts),
    .cmd           (cmd)
  );

  pds_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .cmd     (cmd),
    .sts     (sts),
    .result  (result)
  );

endmodule

>>> rtl/pds_datapath.sv
// Datapath: per-divider division, oscillator accumulator, shift pick, best tracking.
module pds_datapath (
  input  logic              clk,
  input  logic              rst,
  input  pds_pkg::pds_in_t  request,
  input  pds_pkg::pds_cmd_t cmd,
  output pds_pkg::pds_sts_t sts,
  output pds_pkg::pds_out_t result
);
  import pds_pkg::*;

  logic [HZ_W-1:0]    ref_hz;
  logic [HZ_W-1:0]    req_hz;
  logic [HZ_W-1:0]    dq;
  logic [PRE_W-1:0]   rem;
  logic [ICO_W-1:0]   ico;
  logic [PRE_W-1:0]   frac;

  logic               cand_valid;
  logic [HZ_W-1:0]    cand_hz;
  logic [PRE_W-1:0]   cand_pre;
  logic [MUL_W-1:0]   cand_mul;
  logic [SHIFT_W-1:0] cand_sh;

  logic [HZ_W-1:0]    best_hz;
  logic [PRE_W-1:0]   best_pre;
  logic [MUL_W-1:0]   best_mul;
  logic [SHIFT_W-1:0] best_sh;
  logic               best_found;

  logic [DIV_W-1:0]   divisor;
  logic [DIV_W-1:0]   rem_sh;
  logic               rem_ge;
  logic [DIV_W-1:0]   frac_sum;
  logic               carry;
  logic [ICO_W-1:0]   fit;
  logic               fit_any;
  logic [SHIFT_W-1:0] sh_sel;
  logic               ico_ok;

  assign divisor  = {1'b0, cmd.pre} + DIV_W'(1);
  assign rem_sh   = {rem, dq[HZ_W-1]};
  assign rem_ge   = rem_sh >= divisor;
  assign frac_sum = {1'b0, frac} + {1'b0, rem};
  assign carry    = frac_sum >= divisor;
  assign ico_ok   = ico >= ICO_FLOOR_HZ;
  assign sts.pre_ok = dq >= REF_FLOOR_HZ;

  // Smallest shift whose nonzero output fits under the request.
  always_comb begin
    logic [ICO_W-1:0] shifted;
    fit = '0;
    sh_sel = '0;
    for (int i = 0; i < ICO_W; i++) begin
      shifted = ico >> i;
      fit[i] = (shifted != '0) && (shifted <= {{(ICO_W-HZ_W){1'b0}}, req_hz});
    end
    fit_any = |fit;
    for (int i = ICO_W - 1; i >= 0; i--) begin
      if (fit[i]) sh_sel = SHIFT_W'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ref_hz <= request.reference_hz;
      req_hz <= request.requested_hz;
    end
    if (cmd.div_init) begin
      dq  <= ref_hz;
      rem <= '0;
    end else if (cmd.div_step) begin
      dq  <= {dq[HZ_W-2:0], rem_ge};
      rem <= rem_ge ? PRE_W'(rem_sh - divisor) : rem_sh[PRE_W-1:0];
    end
    if (cmd.acc_init) begin
      ico  <= '0;
      frac <= '0;
    end else if (cmd.acc_step) begin
      ico  <= ico + {{(ICO_W-HZ_W){1'b0}}, dq} + ICO_W'(carry);
      frac <= carry ? PRE_W'(frac_sum - divisor) : frac_sum[PRE_W-1:0];
    end
    cand_hz  <= HZ_W'(ico >> sh_sel);
    cand_pre <= cmd.pre;
    cand_mul <= cmd.mul;
    cand_sh  <= sh_sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cand_valid <= 1'b0;
    end else begin
      cand_valid <= cmd.scan && ico_ok && fit_any;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_found <= 1'b0;
      best_hz    <= '0;
      best_pre   <= '0;
      best_mul   <= '0;
      best_sh    <= '0;
    end else if (cmd.load) begin
      best_found <= 1'b0;
      best_hz    <= '0;
      best_pre   <= '0;
      best_mul   <= '0;
      best_sh    <= '0;
    end else if (cand_valid && (cand_hz > best_hz)) begin
      best_found <= 1'b1;
      best_hz    <= cand_hz;
      best_pre   <= cand_pre;
      best_mul   <= cand_mul;
      best_sh    <= cand_sh;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.publish) begin
      result.prediv_field <= best_pre;
      result.mult_field   <= best_mul;
      result.shift_field  <= best_sh;
      result.achieved_hz  <= best_hz;
      result.found        <= best_found;
    end
  end

endmodule

>>> rtl/pds_ctrl.sv
// Controller: sequences division over all pre-dividers, then warm-up and multiplier scan for those that pass the floor.
module pds_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_ready,
  output logic              result_valid,
  input  logic              result_ready,
  input  pds_pkg::pds_sts_t sts,
  output pds_pkg::pds_cmd_t cmd
);
  import pds_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_INIT  = 8'b00000010,
    S_DIV   = 8'b00000100,
    S_CHECK = 8'b00001000,
    S_WARM  = 8'b00010000,
    S_SCAN  = 8'b00100000,
    S_FLUSH = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [PRE_W-1:0] pre, pre_next;
  logic             result_valid_next;
  logic             last_pre;

  assign request_ready = (state == S_IDLE);
  assign last_pre = (pre == PREDIV_MAX);

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    pre_next   = pre;
    cmd        = '0;
    cmd.pre    = pre;
    cmd.mul    = cnt[MUL_W-1:0];
    result_valid_next = result_valid && !result_ready;
    unique case (state)
      S_IDLE: begin
        if (request_valid) begin
          cmd.load   = 1'b1;
          pre_next   = '0;
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == DIV_STEPS - CNT_W'(1)) begin
          cnt_next   = '0;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.acc_init = 1'b1;
        cnt_next     = '0;
        if (sts.pre_ok) begin
          state_next = S_WARM;
        end else if (last_pre) begin
          state_next = S_FLUSH;
        end else begin
          pre_next   = pre + PRE_W'(1);
          state_next = S_INIT;
        end
      end
      S_WARM: begin
        cmd.acc_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt == MULT_OFFSET - CNT_W'(1)) begin
          cnt_next   = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan     = 1'b1;
        cmd.acc_step = 1'b1;
        cnt_next     = cnt + CNT_W'(1);
        if (cnt[MUL_W-1:0] == MULT_MAX) begin
          cnt_next = '0;
          if (last_pre) begin
            state_next = S_FLUSH;
          end else begin
            pre_next   = pre + PRE_W'(1);
            state_next = S_INIT;
          end
        end
      end
      S_FLUSH: begin
        // the flush state lets the last candidate settle into the best
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!result_valid || result_ready) begin
          cmd.publish       = 1'b1;
          result_valid_next = 1'b1;
          state_next        = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cnt          <= '0;
      pre          <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      cnt          <= cnt_next;
      pre          <= pre_next;
      result_valid <= result_valid_next;
    end
  end

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    request_valid && request_ready |=> state == S_INIT)
    else $error("accepted request did not start a search");

  a_publish_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> result_valid)
    else $error("published result not presented");

  a_scan_wrap: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && cnt == CNT_W'(MULT_MAX) && !last_pre |=> state == S_INIT && cnt == '0)
    else $error("scan end did not move to next pre-divider");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |-> !cmd.publish)
    else $error("pending result overwritten");

  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV |-> cnt < DIV_STEPS)
    else $error("division step count out of range");

endmodule
